// ===== rtl/bdph_pkg.sv =====
`default_nettype none

package bdph_pkg;

  localparam int unsigned TICK_W   = 32;
  localparam int unsigned THRESH_W = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Register indexes on the configuration channel.
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TICKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LOW     = 2'd2;

  localparam logic [THRESH_W-1:0] DEBOUNCE_TICKS_RST = 16'd50;
  localparam logic [THRESH_W-1:0] HOLD_TICKS_RST     = 16'd800;
  localparam logic                ACTIVE_LOW_RST     = 1'b1;

  localparam logic EVENT_PRESS = 1'b0;
  localparam logic EVENT_HOLD  = 1'b1;

endpackage : bdph_pkg

`default_nettype wire

// ===== rtl/bdph_if.sv =====
`default_nettype none

interface bdph_sample_if import bdph_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              pin_level;
  logic [TICK_W-1:0] now_tick;

  modport source (output valid, output pin_level, output now_tick, input ready);
  modport sink   (input valid, input pin_level, input now_tick, output ready);
endinterface : bdph_sample_if

interface bdph_event_if;
  logic valid;
  logic ready;
  logic event_kind;

  modport source (output valid, output event_kind, input ready);
  modport sink   (input valid, input event_kind, output ready);
endinterface : bdph_event_if

interface bdph_cfg_if import bdph_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface : bdph_cfg_if

`default_nettype wire

// ===== rtl/button_debounce_press_hold_top.sv =====
`default_nettype none
// Path: a sample request is registered in the sample register at acceptance, and its event,
// if any, moves into the event register and from there is presented on the event channel.
// Throughput: one sample per cycle unless a held event stalls the event channel; the phase
// update is one subtract, two compares and a next-state choice between the sample register
// and the event register. Reset (rst, synchronous, active high): phase idle, entry tick zero,
// thresholds 50 and 800 ticks, active-low button, both pipeline stages empty.

module button_debounce_press_hold_top import bdph_pkg::*; (
  input  wire              clk,
  input  wire              rst,
  bdph_sample_if.sink      smp,
  bdph_cfg_if.sink         cfg,
  bdph_event_if.source     evt
);

  typedef enum logic [1:0] {
    PH_IDLE        = 2'd0,
    PH_DEBOUNCING  = 2'd1,
    PH_PRESSED     = 2'd2,
    PH_WAIT_RELEASE = 2'd3
  } phase_t;

  logic [THRESH_W-1:0] debounce_ticks;
  logic [THRESH_W-1:0] hold_ticks;
  logic                active_low;

  phase_t              phase;
  phase_t              phase_next;
  logic [TICK_W-1:0]   entry_tick;
  logic [TICK_W-1:0]   entry_tick_next;

  // Sample register.
  logic                s_valid;
  logic                s_level;
  logic [TICK_W-1:0]   s_tick;

  // Event register.
  logic                e_valid;
  logic                e_kind;

  logic                advance;
  logic                pressed;
  logic [TICK_W-1:0]   elapsed;
  logic                debounce_met;
  logic                hold_met;
  logic                fire;
  logic                fire_kind;

  assign cfg.ready = 1'b1;

  assign advance   = s_valid && (!e_valid || evt.ready);
  assign smp.ready = !s_valid || advance;

  assign evt.valid      = e_valid;
  assign evt.event_kind = e_kind;

  assign pressed      = active_low ? !s_level : s_level;
  assign elapsed      = s_tick - entry_tick;
  assign debounce_met = elapsed >= {{(TICK_W-THRESH_W){1'b0}}, debounce_ticks};
  assign hold_met     = elapsed >= {{(TICK_W-THRESH_W){1'b0}}, hold_ticks};

  always_comb begin
    phase_next      = phase;
    entry_tick_next = entry_tick;
    fire            = 1'b0;
    fire_kind       = EVENT_PRESS;
    case (phase)
      PH_IDLE: begin
        if (pressed) begin
          phase_next      = PH_DEBOUNCING;
          entry_tick_next = s_tick;
        end
      end
      PH_DEBOUNCING: begin
        // A bounce drops back to idle and keeps the old entry tick.
        if (!pressed) begin
          phase_next = PH_IDLE;
        end else if (debounce_met) begin
          phase_next      = PH_PRESSED;
          entry_tick_next = s_tick;
        end
      end
      PH_PRESSED: begin
        // Release is checked first, so it wins over a hold on the same sample.
        if (!pressed) begin
          fire            = 1'b1;
          fire_kind       = EVENT_PRESS;
          phase_next      = PH_WAIT_RELEASE;
          entry_tick_next = s_tick;
        end else if (hold_met) begin
          fire            = 1'b1;
          fire_kind       = EVENT_HOLD;
          phase_next      = PH_WAIT_RELEASE;
          entry_tick_next = s_tick;
        end
      end
      PH_WAIT_RELEASE: begin
        if (pressed) begin
          entry_tick_next = s_tick;
        end else if (debounce_met) begin
          phase_next = PH_IDLE;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks <= DEBOUNCE_TICKS_RST;
      hold_ticks     <= HOLD_TICKS_RST;
      active_low     <= ACTIVE_LOW_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_DEBOUNCE_TICKS: debounce_ticks <= cfg.data[THRESH_W-1:0];
        REG_HOLD_TICKS:     hold_ticks     <= cfg.data[THRESH_W-1:0];
        REG_ACTIVE_LOW:     active_low     <= cfg.data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (smp.ready) begin
      s_valid <= smp.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (smp.ready && smp.valid) begin
      s_level <= smp.pin_level;
      s_tick  <= smp.now_tick;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      entry_tick <= '0;
      e_valid    <= 1'b0;
      e_kind     <= EVENT_PRESS;
    end else begin
      if (advance && fire) begin
        e_valid <= 1'b1;
      end else if (evt.ready) begin
        e_valid <= 1'b0;
      end
      if (advance) begin
        phase      <= phase_next;
        entry_tick <= entry_tick_next;
        if (fire) begin
          e_kind <= fire_kind;
        end
      end
    end
  end

endmodule : button_debounce_press_hold_top

`default_nettype wire

// ===== test/button_event_checker.sv =====
`default_nettype none

module button_event_checker import bdph_pkg::*; (
  input  wire         clk,
  input  wire         rst,
  bdph_sample_if      smp,
  bdph_cfg_if         cfg,
  bdph_event_if       evt,
  output int unsigned mismatch_count,
  output int unsigned events_awaited
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_DEBOUNCING,
    PH_PRESSED,
    PH_WAIT_RELEASE
  } button_phase_t;

  button_phase_t      phase;
  logic [TICK_W-1:0]  entry_tick;
  logic [THRESH_W-1:0] debounce_thr;
  logic [THRESH_W-1:0] hold_thr;
  logic               low_active;

  logic               expected_kinds[$];
  logic               oldest_kind;

  task automatic report_mismatch(input string what);
    $display("%0t ns: event mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  // Advances the button phase by one poll and queues the event it raises, if any.
  task automatic predict_event(input logic lvl, input logic [TICK_W-1:0] now);
    logic              pressed;
    logic [TICK_W-1:0] elapsed;
    pressed = low_active ? (lvl == 1'b0) : (lvl == 1'b1);
    elapsed = now - entry_tick;
    case (phase)
      PH_IDLE: begin
        if (pressed) begin
          phase = PH_DEBOUNCING;
          entry_tick = now;
        end
      end
      PH_DEBOUNCING: begin
        // A bounce drops back to idle without touching the entry tick.
        if (!pressed) begin
          phase = PH_IDLE;
        end else if (elapsed >= debounce_thr) begin
          phase = PH_PRESSED;
          entry_tick = now;
        end
      end
      PH_PRESSED: begin
        // Release is tested before the hold time, so it wins on a tie.
        if (!pressed) begin
          expected_kinds.push_back(EVENT_PRESS);
          phase = PH_WAIT_RELEASE;
          entry_tick = now;
        end else if (elapsed >= hold_thr) begin
          expected_kinds.push_back(EVENT_HOLD);
          phase = PH_WAIT_RELEASE;
          entry_tick = now;
        end
      end
      default: begin
        if (pressed) begin
          entry_tick = now;
        end else if (elapsed >= debounce_thr) begin
          phase = PH_IDLE;
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      phase = PH_IDLE;
      entry_tick = '0;
      debounce_thr = DEBOUNCE_TICKS_RST;
      hold_thr = HOLD_TICKS_RST;
      low_active = ACTIVE_LOW_RST;
      expected_kinds.delete();
      mismatch_count = 0;
    end else begin
      if (evt.valid && evt.ready) begin
        if (expected_kinds.size() == 0) begin
          report_mismatch($sformatf("kind %0d with no event expected", evt.event_kind));
        end else begin
          oldest_kind = expected_kinds.pop_front();
          if (evt.event_kind !== oldest_kind) begin
            report_mismatch($sformatf("kind %0d, expected %0d", evt.event_kind,
                                      oldest_kind));
          end
        end
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_DEBOUNCE_TICKS: debounce_thr = cfg.data;
          REG_HOLD_TICKS:     hold_thr = cfg.data;
          REG_ACTIVE_LOW:     low_active = cfg.data[0];
          default: ;
        endcase
      end
      if (smp.valid && smp.ready) begin
        predict_event(smp.pin_level, smp.now_tick);
      end
    end
    events_awaited <= expected_kinds.size();
  end

endmodule : button_event_checker

`default_nettype wire

// ===== test/tb_top.sv =====
`default_nettype none

module tb_top import bdph_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int unsigned HOLDOFF_CYCLES = 300;
  localparam int unsigned SETTLE_CYCLES = 4;

  logic clk = 1'b0;
  logic rst;

  bdph_sample_if smp_if ();
  bdph_event_if  evt_if ();
  bdph_cfg_if    cfg_if ();

  int unsigned mismatches;
  int unsigned awaited;

  logic               gaps_on;
  logic               holdoff_req;
  logic [TICK_W-1:0]  tick_now;
  logic [THRESH_W-1:0] cur_deb;
  logic [THRESH_W-1:0] cur_hold;
  logic               cur_al;

  button_debounce_press_hold_top uut (
    .clk (clk),
    .rst (rst),
    .smp (smp_if),
    .cfg (cfg_if),
    .evt (evt_if)
  );

  button_event_checker chk (
    .clk            (clk),
    .rst            (rst),
    .smp            (smp_if),
    .cfg            (cfg_if),
    .evt            (evt_if),
    .mismatch_count (mismatches),
    .events_awaited (awaited)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Event receiver: random stalls, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (holdoff_req) begin
        holdoff_req = 1'b0;
        repeat (HOLDOFF_CYCLES) begin
          evt_if.ready <= 1'b0;
          @(posedge clk);
        end
      end
      evt_if.ready <= (gaps_on && $urandom_range(99) < 9) ? 1'b0 : 1'b1;
    end
  end

  task automatic send_sample(input logic lvl, input logic [TICK_W-1:0] t);
    while (gaps_on && $urandom_range(99) < 9) begin
      smp_if.valid <= 1'b0;
      @(posedge clk);
    end
    smp_if.valid <= 1'b1;
    smp_if.pin_level <= lvl;
    smp_if.now_tick <= t;
    do @(posedge clk); while (!smp_if.ready);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= d;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Stop offering samples and let every pending event come out.
  task automatic drain_events();
    smp_if.valid <= 1'b0;
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [THRESH_W-1:0] deb,
                                input logic [THRESH_W-1:0] hold, input logic al);
    drain_events();
    write_reg(REG_DEBOUNCE_TICKS, deb);
    write_reg(REG_HOLD_TICKS, hold);
    // Only bit 0 matters; the rest carry noise.
    write_reg(REG_ACTIVE_LOW, {15'($urandom_range(32767)), al});
    cur_deb = deb;
    cur_hold = hold;
    cur_al = al;
  endtask

  function automatic logic [THRESH_W-1:0] pick_threshold();
    return ($urandom_range(99) < 80) ? THRESH_W'($urandom_range(40))
                                     : THRESH_W'($urandom_range(65535));
  endfunction

  // Button gestures: dwell times chosen around the thresholds, with glitches
  // and the odd huge tick jump.
  task automatic run_gestures(input int n_items);
    int unsigned step_max;
    int unsigned dwell;
    int unsigned step;
    logic        want;
    logic        lvl;
    logic        press_lvl;
    step_max = 1 + (cur_deb + cur_hold) / 8;
    press_lvl = cur_al ? 1'b0 : 1'b1;
    want = 1'b0;
    dwell = 0;
    for (int i = 0; i < n_items; i++) begin
      if (dwell == 0) begin
        want = ~want;
        case ($urandom_range(3))
          0: dwell = $urandom_range(cur_deb);
          1: dwell = cur_deb + $urandom_range(cur_hold);
          2: dwell = cur_deb + cur_hold + $urandom_range(4 * step_max);
          default: dwell = $urandom_range(3 * step_max);
        endcase
      end
      step = $urandom_range(step_max);
      if ($urandom_range(99) < 2) begin
        step = $urandom;
      end
      lvl = want ? press_lvl : ~press_lvl;
      if ($urandom_range(99) < 8) begin
        lvl = ~lvl;
      end
      tick_now = tick_now + step;
      dwell = (dwell > step) ? dwell - step : 0;
      send_sample(lvl, tick_now);
    end
  endtask

  initial begin
    logic [TICK_W-1:0] t;
    rst = 1'b1;
    gaps_on = 1'b1;
    holdoff_req = 1'b0;
    smp_if.valid = 1'b0;
    smp_if.pin_level = 1'b1;
    smp_if.now_tick = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    evt_if.ready = 1'b0;
    cur_deb = DEBOUNCE_TICKS_RST;
    cur_hold = HOLD_TICKS_RST;
    cur_al = ACTIVE_LOW_RST;
    tick_now = $urandom;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed polls under the reset thresholds, starting just below the wrap.
    t = 32'hFFFF_FFF0;
    send_sample(1'b1, t);
    send_sample(1'b0, t);
    send_sample(1'b1, t + 32'd5);
    send_sample(1'b0, t + 32'd10);
    send_sample(1'b0, t + 32'd60);
    send_sample(1'b1, t + 32'd61);
    send_sample(1'b0, t + 32'd63);
    send_sample(1'b1, t + 32'd70);
    send_sample(1'b1, t + 32'd120);
    t = t + 32'd200;
    send_sample(1'b0, t);
    send_sample(1'b0, t + 32'd50);
    send_sample(1'b0, t + 32'd849);
    send_sample(1'b0, t + 32'd850);
    send_sample(1'b0, t + 32'd2000);
    send_sample(1'b1, t + 32'd2010);
    send_sample(1'b1, t + 32'd2100);
    // Release arriving after the hold time is already due.
    t = t + 32'd3000;
    send_sample(1'b0, t);
    send_sample(1'b0, t + 32'd50);
    send_sample(1'b1, t + 32'd950);
    send_sample(1'b1, t + 32'd1100);
    send_sample(1'b1, 32'd0);
    send_sample(1'b0, 32'hFFFF_FFFF);
    send_sample(1'b0, 32'd49);
    send_sample(1'b1, 32'd50);
    send_sample(1'b1, 32'd200);

    // Zero thresholds fire events nearly every few polls, so the long
    // receiver hold-off backs the block up here.
    apply_settings('0, '0, 1'b0);
    holdoff_req = 1'b1;
    run_gestures(150);

    apply_settings('1, '1, 1'b1);
    write_reg(REG_UNUSED, 16'($urandom));
    run_gestures(150);

    apply_settings(pick_threshold(), pick_threshold(), 1'($urandom_range(1)));
    gaps_on = 1'b0;
    run_gestures(300);
    gaps_on = 1'b1;

    repeat (5) begin
      apply_settings(pick_threshold(), pick_threshold(), 1'($urandom_range(1)));
      run_gestures(150);
    end

    drain_events();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && awaited == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule : tb_top

`default_nettype wire
